### sv/gpct_pkg.sv
`default_nettype none
package gpct_pkg;

    localparam int TABLE_ENTRIES_DEF     = 4096;
    localparam int GROUP_OFFSET_BITS_DEF = 39;
    localparam int PAGES_PER_GROUP       = 4;
    localparam int PAGE_INDEX_W          = 41;
    localparam int CFG_INDEX_W           = 8;

    localparam logic [31:0] ID_AFTER_WRAP = 32'd1000000;

    localparam logic [31:0] EVAL_PERIOD_RST = 32'd250;
    localparam logic [31:0] THR_DISK_RST    = 32'd50;
    localparam logic [31:0] THR_SSD_RST     = 32'd1000;
    localparam logic [4:0]  PERIODS_RST     = 5'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_EVAL_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_DISK    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_SSD     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIODS     = 8'd3;

    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_REFAULT = 2'd1,
        MODE_EVAL    = 2'd2,
        MODE_RESTART = 2'd3
    } gpct_mode_t;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_MERGED   = 2'd1;
    localparam logic [1:0] KIND_NEW      = 2'd2;
    localparam logic [1:0] KIND_REPLACED = 2'd3;

    // per-transaction commands to the statistics block
    typedef struct packed {
        logic add;
        logic found;
        logic ssd;
        logic eval;
        logic restart;
    } gpct_stat_cmd_t;

endpackage
`default_nettype wire

### sv/ghost_page_cache_thrash_detector.sv
`default_nettype none
// Ghost page cache thrash detector.
// Input channel (s_valid/s_ready): one transaction per page event. Mode add
// records an evicted page and returns its object id, mode refault tests and
// clears a page bit, mode evaluate reports pressure, mode restart forces the
// next evaluate to close the sampling period.
// Result channel (m_valid/m_ready): exactly one result transaction per input.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while the block is idle.
// Entries and hash heads live in two RAMs with registered read data. One
// transaction is in flight at a time. The time from the accepting edge to
// m_valid depends on the mode and on the walks through the entry RAM port:
// the hash chain entries walked and, when an add unlinks a victim, the
// victim chain steps. s_ready comes back with m_valid, so a new transaction
// is accepted only once the last result has been loaded.
// After reset a clearing pass writes every entry and hash head, one per
// cycle (TABLE_ENTRIES of each, 4096 by default); s_ready stays low meanwhile.
// A finished result sits in the output register; a new transaction is
// accepted while it waits, and the next result is held until it is taken.
module ghost_page_cache_thrash_detector
    import gpct_pkg::*;
#(
    parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
    parameter int GROUP_OFFSET_BITS = GROUP_OFFSET_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_mode,
    input  wire logic [31:0]             s_ghost_id,
    input  wire logic [PAGE_INDEX_W-1:0] s_page_index,
    input  wire logic                    s_is_ssd,
    input  wire logic [31:0]             s_now_ms,
    input  wire logic                    s_file_pages_over_half,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [31:0]                  m_ghost_id_out,
    output logic [1:0]                   m_add_kind,
    output logic                         m_refault_hit,
    output logic                         m_pressure,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]             cfg_data
);

    localparam int IDX = $clog2(TABLE_ENTRIES);
    localparam int GOB = GROUP_OFFSET_BITS;
    localparam int EW  = 32 + GOB + PAGES_PER_GROUP + IDX;
    localparam int LG  = IDX;
    localparam int HASH_INT = (1 << ((LG + 1) >> 1)) | (1 << ((LG + 1) >> 2)) | 1;
    localparam logic [IDX-1:0] HASH = IDX'(HASH_INT);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_START  = 12'b0000_0000_0100,
        S_HEAD   = 12'b0000_0000_1000,
        S_WALK   = 12'b0000_0001_0000,
        S_ALLOC  = 12'b0000_0010_0000,
        S_VICT   = 12'b0000_0100_0000,
        S_UHEAD  = 12'b0000_1000_0000,
        S_UWALK  = 12'b0001_0000_0000,
        S_NISSUE = 12'b0010_0000_0000,
        S_NHEAD  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    function automatic logic [IDX-1:0] bucket_f(input logic [31:0] o,
                                                 input logic [GOB-1:0] g);
        logic [2*IDX-1:0] prod;
        logic [IDX+GOB-1:0] gext;
        prod = o[IDX-1:0] * HASH;
        gext = {{IDX{1'b0}}, g};
        return prod[IDX-1:0] + (gext[IDX-1:0] ^ HASH);
    endfunction

    state_t state_reg, state_next;

    // transaction context
    gpct_mode_t           mode_reg;
    logic [31:0]          obj_reg;
    logic [GOB-1:0]       grp_reg;
    logic [3:0]           mask_reg;
    logic                 ssd_reg, over_reg;
    logic [31:0]          now_reg;
    logic [IDX-1:0]       cur_reg, slot_reg, vlink_reg, vb_reg;
    logic [IDX-1:0]       clr_reg, ring_reg;
    logic [31:0]          next_obj_reg, next_obj_inc;
    logic [1:0]           kind_reg;
    logic                 hit_reg, press_reg;

    logic                 m_valid_reg;
    logic [31:0]          m_oid_reg;
    logic [1:0]           m_kind_reg;
    logic                 m_hit_reg, m_press_reg;

    // RAM ports
    logic                 ent_we, head_we;
    logic [IDX-1:0]       ent_waddr, ent_raddr, head_waddr, head_raddr;
    logic [EW-1:0]        ent_wdata, ent_rdata;
    logic [IDX-1:0]       head_wdata, head_rdata;

    logic [31:0]          e_obj;
    logic [GOB-1:0]       e_grp;
    logic [3:0]           e_pages;
    logic [IDX-1:0]       e_link;
    logic                 e_match;

    logic [GOB+PAGE_INDEX_W-3:0] grp_ext;
    gpct_stat_cmd_t       cmd;
    logic                 stat_press;
    logic                 accept;

    assign e_obj   = ent_rdata[EW-1 -: 32];
    assign e_grp   = ent_rdata[IDX+PAGES_PER_GROUP +: GOB];
    assign e_pages = ent_rdata[IDX +: PAGES_PER_GROUP];
    assign e_link  = ent_rdata[IDX-1:0];
    assign e_match = (e_obj == obj_reg) && (e_grp == grp_reg);

    assign grp_ext = {{GOB{1'b0}}, s_page_index[PAGE_INDEX_W-1:2]};

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_ghost_id_out  = m_oid_reg;
    assign m_add_kind      = m_kind_reg;
    assign m_refault_hit   = m_hit_reg;
    assign m_pressure      = m_press_reg;

    assign next_obj_inc = (next_obj_reg + 32'd1 == 32'd0) ? ID_AFTER_WRAP
                                                         : next_obj_reg + 32'd1;

    gpct_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    gpct_ram #(.WIDTH(IDX), .DEPTH(TABLE_ENTRIES)) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    gpct_stats u_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .now_ms    (now_reg),
        .over_half (over_reg),
        .pressure  (stat_press)
    );

    // sequencer: RAM addresses, writes and next state
    always_comb begin
        state_next = state_reg;
        ent_we     = 1'b0;
        ent_waddr  = cur_reg;
        ent_wdata  = ent_rdata;
        ent_raddr  = cur_reg;
        head_we    = 1'b0;
        head_waddr = vb_reg;
        head_wdata = vlink_reg;
        head_raddr = bucket_f(obj_reg, grp_reg);
        cmd        = '0;
        cmd.ssd    = ssd_reg;
        unique case (state_reg)
            S_CLEAR: begin
                ent_we     = 1'b1;
                ent_waddr  = clr_reg;
                ent_wdata  = '0;
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                unique case (mode_reg)
                    MODE_ADD: begin
                        cmd.add    = 1'b1;
                        state_next = (obj_reg == 32'd0) ? S_ALLOC : S_HEAD;
                    end
                    MODE_REFAULT: begin
                        state_next = (obj_reg == 32'd0) ? S_DONE : S_HEAD;
                    end
                    MODE_EVAL: begin
                        cmd.eval   = 1'b1;
                        state_next = S_DONE;
                    end
                    default: begin
                        cmd.restart = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_HEAD: begin
                ent_raddr = head_rdata;
                if (head_rdata == '0) begin
                    state_next = (mode_reg == MODE_ADD) ? S_ALLOC : S_DONE;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                ent_raddr = e_link;
                if (e_match) begin
                    state_next = S_DONE;
                    ent_we     = 1'b1;
                    if (mode_reg == MODE_ADD) begin
                        ent_wdata = {e_obj, e_grp, e_pages | mask_reg, e_link};
                    end else begin
                        ent_we    = (e_pages & mask_reg) != 4'd0;
                        cmd.found = ent_we;
                        ent_wdata = {e_obj, e_grp, e_pages & ~mask_reg, e_link};
                    end
                end else if (e_link == '0) begin
                    state_next = (mode_reg == MODE_ADD) ? S_ALLOC : S_DONE;
                end
            end
            S_ALLOC: begin
                ent_raddr  = ring_reg;
                state_next = S_VICT;
            end
            S_VICT: begin
                head_raddr = bucket_f(e_obj, e_grp);
                state_next = (e_obj != 32'd0) ? S_UHEAD : S_NISSUE;
            end
            S_UHEAD: begin
                ent_raddr = head_rdata;
                if (head_rdata == slot_reg) begin
                    head_we    = 1'b1;
                    state_next = S_NISSUE;
                end else if (head_rdata == '0) begin
                    state_next = S_NISSUE;
                end else begin
                    state_next = S_UWALK;
                end
            end
            S_UWALK: begin
                ent_raddr = e_link;
                if (e_link == slot_reg) begin
                    ent_we     = 1'b1;
                    ent_wdata  = {e_obj, e_grp, e_pages, vlink_reg};
                    state_next = S_NISSUE;
                end else if (e_link == '0) begin
                    state_next = S_NISSUE;
                end
            end
            S_NISSUE: begin
                state_next = S_NHEAD;
            end
            S_NHEAD: begin
                ent_we     = 1'b1;
                ent_waddr  = slot_reg;
                ent_wdata  = {obj_reg, grp_reg, mask_reg, head_rdata};
                head_we    = 1'b1;
                head_waddr = bucket_f(obj_reg, grp_reg);
                head_wdata = slot_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            ring_reg     <= IDX'(1);
            next_obj_reg <= 32'd1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + IDX'(1);
            end
            if (state_reg == S_START && mode_reg == MODE_ADD && obj_reg == 32'd0) begin
                next_obj_reg <= next_obj_inc;
            end
            if (state_reg == S_ALLOC) begin
                ring_reg <= (ring_reg == '1) ? IDX'(1) : ring_reg + IDX'(1);
            end
            // load wins over drain: the register refills in the same cycle
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and context registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= gpct_mode_t'(s_mode);
            obj_reg   <= s_ghost_id;
            grp_reg   <= grp_ext[GOB-1:0];
            mask_reg  <= 4'b0001 << s_page_index[1:0];
            ssd_reg   <= s_is_ssd;
            now_reg   <= s_now_ms;
            over_reg  <= s_file_pages_over_half;
            kind_reg  <= KIND_NONE;
            hit_reg   <= 1'b0;
            press_reg <= 1'b0;
        end
        unique case (state_reg)
            S_START: begin
                if (mode_reg == MODE_ADD && obj_reg == 32'd0) begin
                    obj_reg <= next_obj_reg;
                end
                if (mode_reg == MODE_EVAL) begin
                    press_reg <= stat_press;
                end
            end
            S_HEAD:  cur_reg <= head_rdata;
            S_WALK: begin
                cur_reg <= e_link;
                if (e_match) begin
                    if (mode_reg == MODE_ADD) begin
                        kind_reg <= KIND_MERGED;
                    end else begin
                        hit_reg <= (e_pages & mask_reg) != 4'd0;
                    end
                end
            end
            S_ALLOC: slot_reg <= ring_reg;
            S_VICT: begin
                vlink_reg <= e_link;
                vb_reg    <= bucket_f(e_obj, e_grp);
                kind_reg  <= (e_obj != 32'd0) ? KIND_REPLACED : KIND_NEW;
            end
            S_UHEAD: cur_reg <= head_rdata;
            S_UWALK: cur_reg <= e_link;
            default: ;
        endcase
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_oid_reg   <= (mode_reg == MODE_ADD) ? obj_reg : 32'd0;
            m_kind_reg  <= kind_reg;
            m_hit_reg   <= hit_reg;
            m_press_reg <= press_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready)
        else $error("input accepted during clearing pass");

    a_ring_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_reg != '0)
        else $error("ring pointer reached reserved slot 0");

    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_refault_hit || m_pressure) |-> m_add_kind == KIND_NONE)
        else $error("result mixes add and refault/evaluate fields");

    a_slot_write_new: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NHEAD |-> slot_reg != '0 && obj_reg != 32'd0)
        else $error("new entry written to slot 0 or with empty id");
`endif

endmodule
`default_nettype wire

### sv/gpct_ram.sv
`default_nettype none
module gpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/gpct_stats.sv
`default_nettype none
module gpct_stats
    import gpct_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire gpct_stat_cmd_t         cmd,
    input  wire logic [31:0]            now_ms,
    input  wire logic                   over_half,
    output logic                        pressure
);

    logic [31:0] period_reg, thr_disk_reg, thr_ssd_reg;
    logic [4:0]  periods_reg;
    logic [31:0] added_disk_reg, found_disk_reg, added_ssd_reg, found_ssd_reg;
    logic [31:0] history_reg, start_reg;
    logic        pending_reg;

    logic [31:0] elapsed, history_next, need;
    logic        pend, thr_disk, thr_ssd;

    always_comb begin
        elapsed  = now_ms - start_reg;
        pend     = pending_reg | (elapsed >= period_reg);
        thr_disk = (added_disk_reg >= thr_disk_reg) && (found_disk_reg >= thr_disk_reg)
                   && (found_disk_reg >= (added_disk_reg >> 1));
        thr_ssd  = (added_ssd_reg >= thr_ssd_reg) && (found_ssd_reg >= thr_ssd_reg)
                   && (found_ssd_reg >= (added_ssd_reg >> 1));
        if (pend) begin
            history_next = history_reg << 1;
        end else if (thr_disk || thr_ssd) begin
            history_next = history_reg | 32'd1;
        end else begin
            history_next = history_reg;
        end
        need     = ~(32'hFFFF_FFFF << periods_reg);
        pressure = ((history_next & need) == need) && !over_half;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= EVAL_PERIOD_RST;
            thr_disk_reg   <= THR_DISK_RST;
            thr_ssd_reg    <= THR_SSD_RST;
            periods_reg    <= PERIODS_RST;
            added_disk_reg <= '0;
            found_disk_reg <= '0;
            added_ssd_reg  <= '0;
            found_ssd_reg  <= '0;
            history_reg    <= '0;
            start_reg      <= '0;
            pending_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_EVAL_PERIOD: period_reg   <= cfg_data;
                    CFG_THR_DISK:    thr_disk_reg <= cfg_data;
                    CFG_THR_SSD:     thr_ssd_reg  <= cfg_data;
                    CFG_PERIODS:     periods_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.add) begin
                if (cmd.ssd) begin
                    added_ssd_reg <= added_ssd_reg + 32'd1;
                end else begin
                    added_disk_reg <= added_disk_reg + 32'd1;
                end
            end
            if (cmd.found) begin
                if (cmd.ssd) begin
                    found_ssd_reg <= found_ssd_reg + 32'd1;
                end else begin
                    found_disk_reg <= found_disk_reg + 32'd1;
                end
            end
            if (cmd.restart) begin
                pending_reg <= 1'b1;
            end
            if (cmd.eval) begin
                history_reg <= history_next;
                if (pend) begin
                    added_disk_reg <= '0;
                    found_disk_reg <= '0;
                    added_ssd_reg  <= '0;
                    found_ssd_reg  <= '0;
                    start_reg      <= now_ms;
                    pending_reg    <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire
